### hdl/all_pairs_shortest_path_assert.svh
// ---------------------------------------------------------------------------
// All-pairs shortest path assertion macros
// Concurrent assertion helpers shared by the block's RTL.
// ---------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define APSP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define APSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/apsp_pkg.sv
// ---------------------------------------------------------------------------
// apsp_pkg
// Shared constants, codes and types of the all-pairs shortest path block.
// ---------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

  localparam int VERTICES_DEF    = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed widths of the stream fields
  localparam int IN_KIND_W   = 2;
  localparam int IN_IDX_W    = 3;
  localparam int IN_WEIGHT_W = 16;
  localparam int OUT_DIST_W  = 19;
  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * IN_IDX_W - OUT_DIST_W - 1;

  localparam logic [OUT_DIST_W-1:0] DIST_MAX = '1;

  // Item kinds
  localparam logic [IN_KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [IN_KIND_W-1:0] KIND_PRESENCE = 2'd1;
  localparam logic [IN_KIND_W-1:0] KIND_RUN      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

`default_nettype wire

### hdl/all_pairs_shortest_path.sv
// Load and presence words are taken only while idle. A run visits VERTICES^3
// (k,i,j) triples: a skipped triple passes SCAN only, a relaxed one SCAN, SUM
// and CMP; then each entry goes through EMIT_RD and EMIT_OUT, which waits while out_tvalid is held.
// No new word is taken until a run is done; the single adder serves every triple.
// Reset (rst_n low, synchronous): all distances infinite, all vertices absent.
// ---------------------------------------------------------------------------
// All-pairs shortest path
// Floyd-Warshall relaxation over a stored distance matrix, one shared
// adder and comparator stepped by a small sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module all_pairs_shortest_path
  import apsp_pkg::*;
#(
  parameter int VERTICES    = VERTICES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // row[2:0], col[5:3], weight[21:6], no_edge[22], present[23]
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  wire [IN_TUSER_W-1:0]   in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // from_vertex[2:0], to_vertex[5:3], distance[24:6], reachable[25], zero[31:26]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int IDX_W  = $clog2(VERTICES);
  localparam int DEPTH  = VERTICES * VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIST_W = WEIGHT_BITS + IDX_W;
  localparam int LOAD_W = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int CMP_W  = (DIST_W > OUT_DIST_W) ? DIST_W : OUT_DIST_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VERTICES - 1);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r * VERTICES + c);
  endfunction

  // Input word fields
  logic [IN_KIND_W-1:0]   in_kind;
  logic [IN_IDX_W-1:0]    in_row;
  logic [IN_IDX_W-1:0]    in_col;
  logic [IN_WEIGHT_W-1:0] in_weight;
  logic                   in_no_edge;
  logic                   in_present;
  logic                   in_acc;
  logic                   row_ok;
  logic                   col_ok;

  assign in_kind    = in_tuser[1:0];
  assign in_row     = in_tdata[2:0];
  assign in_col     = in_tdata[5:3];
  assign in_weight  = in_tdata[21:6];
  assign in_no_edge = in_tdata[22];
  assign in_present = in_tdata[23];
  assign in_acc     = in_tvalid && in_tready;
  assign row_ok     = ({1'b0, in_row} < 4'(VERTICES));
  assign col_ok     = ({1'b0, in_col} < 4'(VERTICES));

  // State
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [VERTICES-1:0] present_r, present_nxt;
  logic [DEPTH-1:0]    store_fin_r, store_fin_nxt;
  logic [DEPTH-1:0]    work_fin_r, work_fin_nxt;
  logic [DEPTH-1:0]    dirty_r, dirty_nxt;
  logic [DIST_W:0]     sum_r, sum_nxt;

  logic [DIST_W-1:0] store_mem_r [DEPTH];
  logic [DIST_W-1:0] work_mem_r  [DEPTH];
  logic [DIST_W-1:0] rd_store_a_r, rd_store_b_r, rd_work_a_r, rd_work_b_r;
  logic              rd_dirty_a_r, rd_dirty_b_r;
  logic [DIST_W-1:0] val_a, val_b;

  logic              out_valid_r, out_valid_nxt;
  logic [IN_IDX_W-1:0]   out_from_r, out_from_nxt, out_to_r, out_to_nxt;
  logic [OUT_DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_reach_r, out_reach_nxt;
  logic              out_last_r, out_last_nxt;

  // Sequencer control
  logic [ADDR_W-1:0] addr_ik, addr_kj, addr_ij;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic [ADDR_W-1:0] load_addr;
  logic              store_we;
  logic [DIST_W-1:0] store_wdata;
  logic              work_we;
  logic              relax_ok;
  logic              improve;
  logic              last_triple;
  logic              last_entry;
  logic              out_free;
  logic [IDX_W-1:0]  j_adv, i_adv, k_adv;

  assign addr_ik   = addr_of(i_r, k_r);
  assign addr_kj   = addr_of(k_r, j_r);
  assign addr_ij   = addr_of(i_r, j_r);
  assign load_addr = addr_of(in_row[IDX_W-1:0], in_col[IDX_W-1:0]);

  assign val_a = rd_dirty_a_r ? rd_work_a_r : rd_store_a_r;
  assign val_b = rd_dirty_b_r ? rd_work_b_r : rd_store_b_r;

  assign relax_ok = present_r[k_r] && present_r[i_r] && present_r[j_r] &&
                    (i_r != j_r) && work_fin_r[addr_ik] && work_fin_r[addr_kj];
  assign improve  = !work_fin_r[addr_ij] || (sum_r < {1'b0, val_a});

  assign last_entry  = (i_r == LAST_IDX) && (j_r == LAST_IDX);
  assign last_triple = last_entry && (k_r == LAST_IDX);
  assign out_free    = !out_valid_r || out_tready;

  // Wrap j, then i, then k
  assign j_adv = (j_r == LAST_IDX) ? '0 : j_r + 1'b1;
  assign i_adv = (j_r != LAST_IDX) ? i_r : ((i_r == LAST_IDX) ? '0 : i_r + 1'b1);
  assign k_adv = !last_entry ? k_r : ((k_r == LAST_IDX) ? '0 : k_r + 1'b1);

  assign in_tready = (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_RUN)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (relax_ok) state_nxt = ST_SUM;
        else if (last_triple) state_nxt = ST_EMIT_RD;
      end
      ST_SUM: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = last_triple ? ST_EMIT_RD : ST_SCAN;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) state_nxt = last_entry ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath control
  always_comb begin
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    present_nxt   = present_r;
    store_fin_nxt = store_fin_r;
    work_fin_nxt  = work_fin_r;
    dirty_nxt     = dirty_r;
    sum_nxt       = sum_r;
    store_we      = 1'b0;
    store_wdata   = in_no_edge ? '0 : DIST_W'(in_weight[LOAD_W-1:0]);
    work_we       = 1'b0;
    addr_a        = addr_ij;
    addr_b        = addr_kj;
    out_valid_nxt = out_valid_r && !out_tready;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_dist_nxt  = out_dist_r;
    out_reach_nxt = out_reach_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_LOAD: begin
              if (row_ok && col_ok) begin
                store_we                 = 1'b1;
                store_fin_nxt[load_addr] = !in_no_edge;
              end
            end
            KIND_PRESENCE: begin
              if (row_ok) present_nxt[in_row[IDX_W-1:0]] = in_present;
            end
            KIND_RUN: begin
              // Work copy: finite flags copied, values taken from the store until rewritten
              work_fin_nxt = store_fin_r;
              dirty_nxt    = '0;
              k_nxt        = '0;
              i_nxt        = '0;
              j_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        addr_a = addr_ik;
        if (!relax_ok) begin
          k_nxt = k_adv;
          i_nxt = i_adv;
          j_nxt = j_adv;
        end
      end
      ST_SUM: begin
        sum_nxt = {1'b0, val_a} + {1'b0, val_b};
      end
      ST_CMP: begin
        if (improve) begin
          work_we               = 1'b1;
          work_fin_nxt[addr_ij] = 1'b1;
          dirty_nxt[addr_ij]    = 1'b1;
        end
        k_nxt = k_adv;
        i_nxt = i_adv;
        j_nxt = j_adv;
      end
      ST_EMIT_RD: begin
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_from_nxt  = IN_IDX_W'(i_r);
          out_to_nxt    = IN_IDX_W'(j_r);
          out_reach_nxt = work_fin_r[addr_ij];
          out_last_nxt  = last_entry;
          if (!work_fin_r[addr_ij]) out_dist_nxt = '0;
          else if (CMP_W'(val_a) > CMP_W'(DIST_MAX)) out_dist_nxt = DIST_MAX;
          else out_dist_nxt = OUT_DIST_W'(val_a);
          i_nxt = i_adv;
          j_nxt = j_adv;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      present_r   <= '0;
      store_fin_r <= '0;
      work_fin_r  <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      present_r   <= present_nxt;
      store_fin_r <= store_fin_nxt;
      work_fin_r  <= work_fin_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_dist_r  <= out_dist_nxt;
    out_reach_r <= out_reach_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Stored matrix values
  always_ff @(posedge clk) begin
    if (store_we) store_mem_r[load_addr] <= store_wdata;
    rd_store_a_r <= store_mem_r[addr_a];
    rd_store_b_r <= store_mem_r[addr_b];
  end

  // Work matrix values
  always_ff @(posedge clk) begin
    if (work_we) work_mem_r[addr_ij] <= sum_r[DIST_W-1:0];
    rd_work_a_r  <= work_mem_r[addr_a];
    rd_work_b_r  <= work_mem_r[addr_b];
    rd_dirty_a_r <= dirty_r[addr_a];
    rd_dirty_b_r <= dirty_r[addr_b];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_reach_r, out_dist_r, out_to_r, out_from_r};

`include "all_pairs_shortest_path_assert.svh"

  `APSP_ASSERT_NEXT(a_run_goes_busy, clk, rst_n, in_acc && (in_kind == KIND_RUN), !in_tready, "run word did not leave idle")
  `APSP_ASSERT_SAME(a_unreach_zero, clk, rst_n, out_valid_r && !out_reach_r, out_dist_r == '0, "unreachable entry with nonzero distance")
  `APSP_ASSERT_SAME(a_dirty_is_finite, clk, rst_n, 1'b1, (dirty_r & ~work_fin_r) == '0, "rewritten work entry not finite")

endmodule

`default_nettype wire
